### rtl/dtf_pkg.sv
// Shared constants, types and helper functions of the disparity temporal filter.
`timescale 1ns / 1ps
`default_nettype none

package dtf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_PIXEL_BITS = 16;

    // Queue depths, powers of two.
    localparam int DESC_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH  = 4;

    // Configuration port and register widths.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 10;
    localparam int ALPHA_BITS     = 9;
    localparam int DELTA_BITS     = 16;
    localparam int MODE_BITS      = 4;
    localparam int HIST_BITS      = 8;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_ALPHA  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_DELTA  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERSIST_MODE = 3'd4;

    // Register values after reset.
    localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 10'd480;
    localparam logic [ALPHA_BITS-1:0]  RST_BLEND_ALPHA  = 9'd102;
    localparam logic [DELTA_BITS-1:0]  RST_BLEND_DELTA  = 16'd320;
    localparam logic [MODE_BITS-1:0]   RST_PERSIST_MODE = 4'd3;

    // Alpha of one in Q1.8.
    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 9'd256;

    // Persistence patterns.
    localparam logic [MODE_BITS-1:0] PERSIST_OFF       = 4'd0;
    localparam logic [MODE_BITS-1:0] PERSIST_ALL_8     = 4'd1;
    localparam logic [MODE_BITS-1:0] PERSIST_2_OF_3    = 4'd2;
    localparam logic [MODE_BITS-1:0] PERSIST_2_OF_4    = 4'd3;
    localparam logic [MODE_BITS-1:0] PERSIST_2_OF_8    = 4'd4;
    localparam logic [MODE_BITS-1:0] PERSIST_1_OF_2    = 4'd5;
    localparam logic [MODE_BITS-1:0] PERSIST_1_OF_5    = 4'd6;
    localparam logic [MODE_BITS-1:0] PERSIST_1_OF_8    = 4'd7;
    localparam logic [MODE_BITS-1:0] PERSIST_ALWAYS    = 4'd8;

    // Filter settings seen by the back end.
    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha;
        logic [DELTA_BITS-1:0] delta;
        logic [MODE_BITS-1:0]  mode;
    } dtf_params_t;

    // What the back end does with one pixel.
    typedef enum logic [1:0] {
        ACT_PASS,
        ACT_BLEND,
        ACT_HOLD
    } dtf_action_t;

    function automatic logic [3:0] count_ones(input logic [HIST_BITS-1:0] bits);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < HIST_BITS; i++) begin
            c = c + {3'd0, bits[i]};
        end
        return c;
    endfunction

    // Bit 7 of the history is the oldest sample, bit 0 the newest.
    function automatic logic hold_check(input logic [MODE_BITS-1:0] mode,
                                        input logic [HIST_BITS-1:0] h);
        logic [3:0] s8;
        logic [3:0] s5;
        logic [3:0] s4;
        logic [3:0] s3;
        logic [3:0] s2;
        logic       hold;
        s8 = count_ones(h);
        s5 = count_ones({3'd0, h[7:3]});
        s4 = count_ones({4'd0, h[7:4]});
        s3 = count_ones({5'd0, h[7:5]});
        s2 = count_ones({6'd0, h[7:6]});
        unique case (mode)
            PERSIST_ALL_8:  hold = (s8 >= 4'd8);
            PERSIST_2_OF_3: hold = (s3 >= 4'd2);
            PERSIST_2_OF_4: hold = (s4 >= 4'd2);
            PERSIST_2_OF_8: hold = (s8 >= 4'd2);
            PERSIST_1_OF_2: hold = (s2 >= 4'd1);
            PERSIST_1_OF_5: hold = (s5 >= 4'd1);
            PERSIST_1_OF_8: hold = (s8 >= 4'd1);
            PERSIST_ALWAYS: hold = 1'b1;
            default:        hold = 1'b0;
        endcase
        return hold;
    endfunction

endpackage

`default_nettype wire

### rtl/dtf_fifo.sv
// Small synchronous queue with occupancy count.
`timescale 1ns / 1ps
`default_nettype none

module dtf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    output logic                            full,
    input  wire logic                       rd_en,
    output logic [WIDTH-1:0]                rd_data,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/dtf_front.sv
// Front end: configuration registers, frame position tracking and pixel tagging.
`timescale 1ns / 1ps
`default_nettype none

module dtf_front #(
    parameter int MAX_WIDTH  = dtf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtf_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = dtf_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dtf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [dtf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [PIXEL_BITS-1:0]               disparity_in,
    output logic                                     desc_push,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+PIXEL_BITS+1:0] desc_data,
    input  wire logic                                desc_full,
    output dtf_pkg::dtf_params_t                     params
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int TOT_BITS    = $clog2(STORE_DEPTH + 1);
    localparam int W_BITS      = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS      = $clog2(MAX_HEIGHT + 1);

    logic [dtf_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [dtf_pkg::HEIGHT_BITS-1:0] height_reg;
    logic [dtf_pkg::ALPHA_BITS-1:0]  alpha_reg;
    logic [dtf_pkg::DELTA_BITS-1:0]  delta_reg;
    logic [dtf_pkg::MODE_BITS-1:0]   mode_reg;
    logic                            settle_reg;
    logic [TOT_BITS-1:0]             total_reg;
    logic [TOT_BITS-1:0]             total_next;
    logic [ADDR_BITS-1:0]            pos_reg;
    logic [ADDR_BITS-1:0]            pos_next;
    logic                            first_reg;
    logic                            first_next;

    logic [W_BITS-1:0]               w_eff;
    logic [H_BITS-1:0]               h_eff;
    logic [ADDR_BITS-1:0]            idx_sel;
    logic [TOT_BITS-1:0]             idx_inc;
    logic                            last;
    logic                            size_change;
    logic [dtf_pkg::WIDTH_BITS-1:0]  cfg_width;
    logic [dtf_pkg::HEIGHT_BITS-1:0] cfg_height;

    assign cfg_width  = cfg_data[dtf_pkg::WIDTH_BITS-1:0];
    assign cfg_height = cfg_data[dtf_pkg::HEIGHT_BITS-1:0];

    // Out-of-range sizes are clamped to the supported frame.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = W_BITS'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = W_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_BITS'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = H_BITS'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = H_BITS'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = H_BITS'(height_reg);
        end

        total_next = TOT_BITS'(w_eff) * TOT_BITS'(h_eff);
    end

    assign full      = desc_full || settle_reg;
    assign desc_push = push && !full;

    always_comb
    begin
        idx_sel = (TOT_BITS'(pos_reg) >= total_reg) ? '0 : pos_reg;
        idx_inc = TOT_BITS'(idx_sel) + TOT_BITS'(1);
        last    = (idx_inc >= total_reg);
    end

    assign desc_data = {idx_sel, disparity_in, first_reg, last};

    always_comb
    begin
        size_change = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dtf_pkg::REG_FRAME_WIDTH:  size_change = (cfg_width != width_reg);
                dtf_pkg::REG_FRAME_HEIGHT: size_change = (cfg_height != height_reg);
                default:                   size_change = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        if (size_change)
        begin
            pos_next   = '0;
            first_next = 1'b1;
        end
        else if (desc_push)
        begin
            if (last)
            begin
                pos_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                pos_next = ADDR_BITS'(idx_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dtf_pkg::RST_FRAME_WIDTH;
            height_reg <= dtf_pkg::RST_FRAME_HEIGHT;
            alpha_reg  <= dtf_pkg::RST_BLEND_ALPHA;
            delta_reg  <= dtf_pkg::RST_BLEND_DELTA;
            mode_reg   <= dtf_pkg::RST_PERSIST_MODE;
            settle_reg <= 1'b1;
            pos_reg    <= '0;
            first_reg  <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_we;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dtf_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_width;
                    dtf_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_height;
                    dtf_pkg::REG_BLEND_ALPHA:
                        alpha_reg <= cfg_data[dtf_pkg::ALPHA_BITS-1:0];
                    dtf_pkg::REG_BLEND_DELTA:
                        delta_reg <= cfg_data[dtf_pkg::DELTA_BITS-1:0];
                    dtf_pkg::REG_PERSIST_MODE:
                        mode_reg  <= cfg_data[dtf_pkg::MODE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Frame size product, registered from the size registers in the cycle after they change.
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    assign params.alpha = alpha_reg;
    assign params.delta = delta_reg;
    assign params.mode  = mode_reg;

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !settle_reg |-> (TOT_BITS'(pos_reg) < total_reg))
        else $error("frame position outside the frame");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (desc_push && last && !cfg_we) |=> (pos_reg == '0) && !first_reg)
        else $error("last pixel did not close the frame");

endmodule

`default_nettype wire

### rtl/dtf_back.sv
// Back end: frame store read, blend and hold decision, store write-back.
`timescale 1ns / 1ps
`default_nettype none

module dtf_back #(
    parameter int MAX_WIDTH  = dtf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtf_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = dtf_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                desc_empty,
    input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+PIXEL_BITS+1:0] desc_data,
    output logic                                     desc_pop,
    input  wire dtf_pkg::dtf_params_t                params,
    input  wire logic [$clog2(dtf_pkg::OUT_QUEUE_DEPTH+1)-1:0] out_count,
    output logic                                     out_push,
    output logic [PIXEL_BITS:0]                      out_data
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int MEM_BITS    = PIXEL_BITS + dtf_pkg::HIST_BITS;
    localparam int PROD_BITS   = PIXEL_BITS + 10;
    localparam int CMP_BITS    = (PIXEL_BITS > dtf_pkg::DELTA_BITS) ?
                                 PIXEL_BITS : dtf_pkg::DELTA_BITS;
    localparam int HB          = dtf_pkg::HIST_BITS;

    // Head of the descriptor queue.
    logic [ADDR_BITS-1:0]  head_idx;
    logic [PIXEL_BITS-1:0] head_cur;
    logic                  head_first;
    logic                  head_last;

    assign {head_idx, head_cur, head_first, head_last} = desc_data;

    // Frame store: previous output pixel and validity history per entry.
    logic [MEM_BITS-1:0]   store_mem [STORE_DEPTH];
    logic [MEM_BITS-1:0]   rd_data_reg;

    // Stage 1: store data arrives.
    logic                  s1_valid_reg;
    logic [ADDR_BITS-1:0]  s1_idx_reg;
    logic [PIXEL_BITS-1:0] s1_cur_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;

    // Stage 2: finish the blend and write back.
    logic                         s2_valid_reg;
    logic [ADDR_BITS-1:0]         s2_idx_reg;
    logic [PIXEL_BITS-1:0]        s2_cur_reg;
    logic [PIXEL_BITS-1:0]        s2_prev_reg;
    logic signed [PROD_BITS-1:0]  s2_prod_reg;
    dtf_pkg::dtf_action_t         s2_action_reg;
    logic [HB-1:0]                s2_hist_reg;
    logic                         s2_last_reg;

    logic                         hazard;
    logic                         credit_ok;

    logic [PIXEL_BITS-1:0]        prev;
    logic [HB-1:0]                hist_old;
    logic [HB-1:0]                hist_new;
    logic                         cur_ok;
    logic                         prev_ok;
    logic [PIXEL_BITS-1:0]        diff;
    logic                         close;
    logic [dtf_pkg::ALPHA_BITS-1:0] alpha_eff;
    logic signed [PIXEL_BITS:0]   step;
    logic signed [PROD_BITS-1:0]  prod;
    dtf_pkg::dtf_action_t         action;

    logic signed [PROD_BITS-1:0]  acc;
    logic [PIXEL_BITS-1:0]        res;

    // A pixel waits while an older pixel of the same store entry is still in
    // flight, which only happens for frames of one or two pixels.
    assign hazard = (s1_valid_reg && (s1_idx_reg == head_idx)) ||
                    (s2_valid_reg && (s2_idx_reg == head_idx));

    // Room in the result queue for everything already in the pipeline.
    assign credit_ok = (int'(out_count) + int'(s1_valid_reg) + int'(s2_valid_reg))
                       < dtf_pkg::OUT_QUEUE_DEPTH;

    assign desc_pop = !desc_empty && !hazard && credit_ok;

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            rd_data_reg <= store_mem[head_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            store_mem[s2_idx_reg] <= {s2_hist_reg, res};
        end
    end

    // Stage 1 decision and the single multiply.
    always_comb
    begin
        prev      = rd_data_reg[PIXEL_BITS-1:0];
        hist_old  = rd_data_reg[MEM_BITS-1 -: HB];
        cur_ok    = |s1_cur_reg;
        prev_ok   = |prev;
        hist_new  = s1_first_reg ? '0 : {hist_old[HB-2:0], cur_ok};
        diff      = (s1_cur_reg > prev) ? (s1_cur_reg - prev) : (prev - s1_cur_reg);
        close     = CMP_BITS'(diff) < CMP_BITS'(params.delta);
        alpha_eff = (params.alpha > dtf_pkg::ALPHA_ONE) ? dtf_pkg::ALPHA_ONE
                                                        : params.alpha;
        step      = $signed({1'b0, s1_cur_reg}) - $signed({1'b0, prev});
        prod      = $signed({1'b0, alpha_eff}) * step;

        if (s1_first_reg)
        begin
            action = dtf_pkg::ACT_PASS;
        end
        else if (cur_ok && prev_ok && close)
        begin
            action = dtf_pkg::ACT_BLEND;
        end
        else if (!cur_ok && prev_ok && dtf_pkg::hold_check(params.mode, hist_new))
        begin
            action = dtf_pkg::ACT_HOLD;
        end
        else
        begin
            action = dtf_pkg::ACT_PASS;
        end
    end

    // Stage 2: prev*256 + alpha*(cur-prev) + half, then select.
    always_comb
    begin
        acc = $signed({2'b00, s2_prev_reg, 8'd0}) + s2_prod_reg +
              $signed({{(PIXEL_BITS+1){1'b0}}, 9'd128});
        unique case (s2_action_reg)
            dtf_pkg::ACT_PASS:  res = s2_cur_reg;
            dtf_pkg::ACT_BLEND: res = acc[PIXEL_BITS+7:8];
            dtf_pkg::ACT_HOLD:  res = s2_prev_reg;
            default:            res = s2_cur_reg;
        endcase
    end

    assign out_push = s2_valid_reg;
    assign out_data = {res, s2_last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= desc_pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            s1_idx_reg   <= head_idx;
            s1_cur_reg   <= head_cur;
            s1_first_reg <= head_first;
            s1_last_reg  <= head_last;
        end
        s2_idx_reg    <= s1_idx_reg;
        s2_cur_reg    <= s1_cur_reg;
        s2_prev_reg   <= prev;
        s2_prod_reg   <= prod;
        s2_action_reg <= action;
        s2_hist_reg   <= hist_new;
        s2_last_reg   <= s1_last_reg;
    end

    a_pop_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |-> ##2 out_push)
        else $error("pixel lost between queue and result");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (int'(out_count) < dtf_pkg::OUT_QUEUE_DEPTH))
        else $error("result pushed into a full queue");

    a_distinct_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_idx_reg != s2_idx_reg))
        else $error("two pixels of one store entry in flight");

endmodule

`default_nettype wire

### rtl/disparity_temporal_filter.sv
// Top level of the disparity temporal filter: front end, queues and back end.
`timescale 1ns / 1ps
`default_nettype none

// Temporal filter for a raster stream of disparity pixels (0 means invalid).
// Input channel: a pixel transfer happens at a rising edge with push high and
// full low. Result channel: the oldest filtered pixel and its frame_end flag
// sit on the output ports while empty is low; a transfer happens at an edge
// with pop high and empty low. The configuration port takes one register write
// per edge with cfg_we high; write only while no pixel is in flight.
// Throughput is one pixel per cycle while the result channel is not stalled, set
// by the single read and single write port of the frame store. For frames of one
// or two pixels a pixel waits until the previous pixel of the same store entry
// has been written back, so such frames stream more slowly.
// An accepted pixel passes the descriptor queue, the store read, the multiply
// and the write into the result queue before it is on the result ports.
// full is also high for the cycle after each configuration write and the cycle
// after reset, while the frame size product settles.
// After reset the registers hold their defaults and the next frame passes
// through unchanged while it seeds the frame store and clears the histories.
// When the receiver stalls, results collect in a four-entry queue, the back end
// stops taking pixels, and full rises once the front queue fills.
module disparity_temporal_filter #(
    parameter int MAX_WIDTH  = dtf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtf_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = dtf_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dtf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [dtf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [PIXEL_BITS-1:0]               disparity_in,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [PIXEL_BITS-1:0]                    disparity_out,
    output logic                                     frame_end
);

    localparam int ADDR_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DESC_BITS = ADDR_BITS + PIXEL_BITS + 2;
    localparam int OUT_BITS  = PIXEL_BITS + 1;
    localparam int OUT_CNT_BITS = $clog2(dtf_pkg::OUT_QUEUE_DEPTH + 1);

    // Pixel descriptors from the front end to the back end.
    logic                  desc_push;
    logic [DESC_BITS-1:0]  desc_wdata;
    logic                  desc_full;
    logic                  desc_pop;
    logic [DESC_BITS-1:0]  desc_rdata;
    logic                  desc_empty;

    // Filtered pixels from the back end to the result channel.
    logic                  out_push;
    logic [OUT_BITS-1:0]   out_wdata;
    logic [OUT_BITS-1:0]   out_rdata;
    logic [OUT_CNT_BITS-1:0] out_count;

    dtf_pkg::dtf_params_t  params;

    dtf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .disparity_in (disparity_in),
        .desc_push    (desc_push),
        .desc_data    (desc_wdata),
        .desc_full    (desc_full),
        .params       (params)
    );

    dtf_fifo #(
        .WIDTH (DESC_BITS),
        .DEPTH (dtf_pkg::DESC_QUEUE_DEPTH)
    ) u_desc_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc_wdata),
        .full    (desc_full),
        .rd_en   (desc_pop),
        .rd_data (desc_rdata),
        .empty   (desc_empty),
        .count   ()
    );

    dtf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_empty (desc_empty),
        .desc_data  (desc_rdata),
        .desc_pop   (desc_pop),
        .params     (params),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_data   (out_wdata)
    );

    // The back end only pushes when it holds credit, so full is not needed.
    dtf_fifo #(
        .WIDTH (OUT_BITS),
        .DEPTH (dtf_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wdata),
        .full    (),
        .rd_en   (pop),
        .rd_data (out_rdata),
        .empty   (empty),
        .count   (out_count)
    );

    assign disparity_out = out_rdata[OUT_BITS-1:1];
    assign frame_end     = out_rdata[0];

endmodule

`default_nettype wire
